### rtl/rost_pkg.sv
package rost_pkg;

   localparam int ENTRIES     = 16;
   localparam int SECTOR_BITS = 16;
   localparam int COUNT_BITS  = 8;

   localparam int IDX_BITS = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   localparam int MODE_BITS       = 2;
   localparam int REQ_SECTOR_BITS = 16;
   localparam int SLOT_BITS       = 4;
   localparam int OPEN_COUNT_BITS = 8;
   localparam int STATUS_BITS     = 2;

   localparam logic [MODE_BITS-1:0] MODE_OPEN  = 2'd0;
   localparam logic [MODE_BITS-1:0] MODE_CLOSE = 2'd1;
   localparam logic [MODE_BITS-1:0] MODE_QUERY = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_UNKNOWN  = 2'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_OVERFLOW = 2'd3;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [IDX_BITS-1:0]   IDX_LAST  = IDX_BITS'(ENTRIES - 1);

   typedef struct packed {
      logic [SECTOR_BITS-1:0] sector;
      logic [COUNT_BITS-1:0]  count;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

endpackage

### rtl/rost_ram.sv
module rost_ram #(
   parameter int WIDTH     = 24,
   parameter int DEPTH     = 16,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/refcounted_open_sector_table.sv
// Reference-counted table of open sectors. Each request transfer names a sector and a mode
// (open, close, query) and produces exactly one response transfer carrying the slot handle,
// the open count after the request, whether the sector is now absent, and a status code.
// Requests are handled one at a time: after the request transfer the sector/count RAM is
// read one slot a cycle for all ENTRIES slots, then a settling state lets the registered
// read data be compared and an update state writes the table and the response; the update
// waits while an earlier response is still stalled, and the next request is taken only
// after it. The single RAM read port is why the slots are read in turn. The response
// sits in an output register, so the next request may be taken while a response is still
// stalled; valid bits are cleared by reset, the RAM needs no clearing pass.
module refcounted_open_sector_table (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [rost_pkg::MODE_BITS-1:0]       req_mode,
   input  logic [rost_pkg::REQ_SECTOR_BITS-1:0] req_sector,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [rost_pkg::SLOT_BITS-1:0]       rsp_slot,
   output logic [rost_pkg::OPEN_COUNT_BITS-1:0] rsp_open_count,
   output logic                                 rsp_removable,
   output logic [rost_pkg::STATUS_BITS-1:0]     rsp_status
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SCAN   = 4'b0010,
      ST_SETTLE = 4'b0100,
      ST_UPDATE = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [rost_pkg::ENTRIES-1:0]     valid_ff, valid_in;
   logic [rost_pkg::IDX_BITS-1:0]    idx_ff, idx_in;
   logic                             rd_pend_ff, rd_pend_in;
   logic [rost_pkg::IDX_BITS-1:0]    rd_idx_ff;
   logic [rost_pkg::MODE_BITS-1:0]   mode_ff;
   logic [rost_pkg::SECTOR_BITS-1:0] key_ff;
   logic                             found_ff, found_in;
   logic [rost_pkg::IDX_BITS-1:0]    hit_idx_ff, hit_idx_in;
   logic [rost_pkg::COUNT_BITS-1:0]  hit_count_ff, hit_count_in;
   logic                             free_ff, free_in;
   logic [rost_pkg::IDX_BITS-1:0]    free_idx_ff, free_idx_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic [rost_pkg::SLOT_BITS-1:0]       rsp_slot_ff;
   logic [rost_pkg::OPEN_COUNT_BITS-1:0] rsp_open_count_ff;
   logic                                 rsp_removable_ff;
   logic [rost_pkg::STATUS_BITS-1:0]     rsp_status_ff;

   rost_pkg::entry_type rd_entry, wr_entry;
   logic [rost_pkg::ENTRY_BITS-1:0] rd_data;
   logic                            req_take;
   logic                            rd_hit, rd_free;
   logic                            update_go;
   logic                            wr_en, set_valid, clr_valid;
   logic [rost_pkg::IDX_BITS-1:0]   upd_idx;
   logic [rost_pkg::COUNT_BITS-1:0] count_step;
   logic [rost_pkg::IDX_BITS-1:0]   res_idx;
   logic [rost_pkg::COUNT_BITS-1:0] res_count;
   logic                            res_removable;
   logic [rost_pkg::STATUS_BITS-1:0] res_status;

   rost_ram #(
      .WIDTH (rost_pkg::ENTRY_BITS),
      .DEPTH (rost_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en && update_go),
      .wr_addr (upd_idx),
      .wr_data (wr_entry),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign rd_entry  = rost_pkg::entry_type'(rd_data);
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign update_go = (state_ff == ST_UPDATE) && (!rsp_valid_ff || !rsp_stall);

   // one compare per cycle on the registered read
   assign rd_hit  = rd_pend_ff && valid_ff[rd_idx_ff] && (rd_entry.sector == key_ff);
   assign rd_free = rd_pend_ff && !valid_ff[rd_idx_ff];

   // shared count adder, increments for open and decrements for close
   assign count_step = hit_count_ff +
                       ((mode_ff == rost_pkg::MODE_CLOSE) ? rost_pkg::COUNT_MAX
                                                          : rost_pkg::COUNT_BITS'(1));

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      rd_pend_in   = (state_ff == ST_SCAN);
      found_in     = found_ff;
      hit_idx_in   = hit_idx_ff;
      hit_count_in = hit_count_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
               idx_in   = '0;
               found_in = 1'b0;
               free_in  = 1'b0;
            end
         end
         ST_SCAN: begin
            if (idx_ff == rost_pkg::IDX_LAST) begin
               state_in = ST_SETTLE;
            end else begin
               idx_in = idx_ff + rost_pkg::IDX_BITS'(1);
            end
         end
         ST_SETTLE: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (update_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (rd_hit && !found_ff) begin
         found_in     = 1'b1;
         hit_idx_in   = rd_idx_ff;
         hit_count_in = rd_entry.count;
      end
      if (rd_free && !free_ff) begin
         free_in     = 1'b1;
         free_idx_in = rd_idx_ff;
      end
   end

   always_comb begin
      wr_en           = 1'b0;
      set_valid       = 1'b0;
      clr_valid       = 1'b0;
      upd_idx         = hit_idx_ff;
      wr_entry.sector = key_ff;
      wr_entry.count  = count_step;
      res_idx         = '0;
      res_count       = '0;
      res_removable   = 1'b1;
      res_status      = rost_pkg::STATUS_OK;
      case (mode_ff)
         rost_pkg::MODE_OPEN: begin
            if (found_ff) begin
               res_idx       = hit_idx_ff;
               res_removable = 1'b0;
               if (hit_count_ff == rost_pkg::COUNT_MAX) begin
                  res_count  = rost_pkg::COUNT_MAX;
                  res_status = rost_pkg::STATUS_OVERFLOW;
               end else begin
                  wr_en     = 1'b1;
                  res_count = count_step;
               end
            end else if (free_ff) begin
               wr_en          = 1'b1;
               set_valid      = 1'b1;
               upd_idx        = free_idx_ff;
               wr_entry.count = rost_pkg::COUNT_BITS'(1);
               res_idx        = free_idx_ff;
               res_count      = rost_pkg::COUNT_BITS'(1);
               res_removable  = 1'b0;
            end else begin
               res_status = rost_pkg::STATUS_FULL;
            end
         end
         rost_pkg::MODE_CLOSE: begin
            if (!found_ff) begin
               res_status = rost_pkg::STATUS_UNKNOWN;
            end else if (hit_count_ff > rost_pkg::COUNT_BITS'(1)) begin
               wr_en         = 1'b1;
               res_idx       = hit_idx_ff;
               res_count     = count_step;
               res_removable = 1'b0;
            end else begin
               clr_valid = 1'b1;
               res_idx   = hit_idx_ff;
            end
         end
         default: begin
            if (found_ff) begin
               res_idx       = hit_idx_ff;
               res_count     = hit_count_ff;
               res_removable = 1'b0;
            end
         end
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (update_go && set_valid) begin
         valid_in[upd_idx] = 1'b1;
      end
      if (update_go && clr_valid) begin
         valid_in[upd_idx] = 1'b0;
      end
   end

   assign rsp_valid_in = update_go || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         found_ff     <= 1'b0;
         free_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         rd_pend_ff   <= rd_pend_in;
         found_ff     <= found_in;
         free_ff      <= free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      rd_idx_ff    <= idx_ff;
      hit_idx_ff   <= hit_idx_in;
      hit_count_ff <= hit_count_in;
      free_idx_ff  <= free_idx_in;
      if (req_take) begin
         mode_ff <= req_mode;
         key_ff  <= rost_pkg::SECTOR_BITS'(req_sector);
      end
      if (update_go) begin
         rsp_slot_ff       <= rost_pkg::SLOT_BITS'(res_idx);
         rsp_open_count_ff <= rost_pkg::OPEN_COUNT_BITS'(res_count);
         rsp_removable_ff  <= res_removable;
         rsp_status_ff     <= res_status;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_open_count = rsp_open_count_ff;
   assign rsp_removable  = rsp_removable_ff;
   assign rsp_status     = rsp_status_ff;

   a_hit_is_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE) && found_ff |-> valid_ff[hit_idx_ff])
      else $error("matched slot is not valid at update");

   a_take_starts_scan: assert property (@(posedge clock) disable iff (reset)
      req_take |=> (state_ff == ST_SCAN) && (idx_ff == '0))
      else $error("request transfer did not start the scan");

   a_absent_has_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_removable |-> (rsp_open_count == '0))
      else $error("absent sector reported with a non-zero count");

   a_overflow_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == rost_pkg::STATUS_OVERFLOW) |->
         (rsp_open_count == rost_pkg::OPEN_COUNT_BITS'(rost_pkg::COUNT_MAX)) && !rsp_removable)
      else $error("overflow response without a saturated count");

endmodule

### verif/tb_refcounted_open_sector_table.sv
`timescale 1ns / 1ps

module tb_refcounted_open_sector_table;
   import rost_pkg::*;

   localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
   localparam int POOL_SIZE     = 24;
   localparam int RANDOM_ITEMS  = 500;
   localparam int HAMMER_AT     = 150;
   localparam int HAMMER_OPENS  = 260;
   localparam int DIRECTED_ROWS = 15;

   typedef struct packed {
      logic [SLOT_BITS-1:0]       slot;
      logic [OPEN_COUNT_BITS-1:0] open_count;
      logic                       removable;
      logic [STATUS_BITS-1:0]     status;
   } sector_reply_t;

   typedef struct packed {
      logic [MODE_BITS-1:0]       mode;
      logic [REQ_SECTOR_BITS-1:0] sector;
      int                         reps;
      bit                         typed;
      sector_reply_t              reply;
   } sector_row_t;

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [MODE_BITS-1:0]       req_mode;
   logic [REQ_SECTOR_BITS-1:0] req_sector;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic [SLOT_BITS-1:0]       rsp_slot;
   logic [OPEN_COUNT_BITS-1:0] rsp_open_count;
   logic                       rsp_removable;
   logic [STATUS_BITS-1:0]     rsp_status;

   // predicted table contents
   logic                   slot_valid  [ENTRIES];
   logic [SECTOR_BITS-1:0] slot_sector [ENTRIES];
   logic [COUNT_BITS-1:0]  slot_count  [ENTRIES];

   sector_reply_t awaited_replies [$];
   int unsigned   fault_count = 0;
   logic [REQ_SECTOR_BITS-1:0] key_pool [POOL_SIZE];

   sector_row_t directed_rows [DIRECTED_ROWS] = '{
      '{MODE_QUERY, 16'h0000, 1,  1'b1, '{4'd0, 8'd0, 1'b1, STATUS_OK}},
      '{MODE_CLOSE, 16'hFFFF, 1,  1'b1, '{4'd0, 8'd0, 1'b1, STATUS_UNKNOWN}},
      '{MODE_OPEN,  16'h0000, 1,  1'b1, '{4'd0, 8'd1, 1'b0, STATUS_OK}},
      '{MODE_OPEN,  16'hFFFF, 1,  1'b1, '{4'd1, 8'd1, 1'b0, STATUS_OK}},
      '{MODE_OPEN,  16'h0000, 1,  1'b1, '{4'd0, 8'd2, 1'b0, STATUS_OK}},
      '{MODE_SPARE, 16'h0000, 1,  1'b1, '{4'd0, 8'd2, 1'b0, STATUS_OK}},
      '{MODE_CLOSE, 16'h0000, 1,  1'b1, '{4'd0, 8'd1, 1'b0, STATUS_OK}},
      '{MODE_CLOSE, 16'h0000, 1,  1'b1, '{4'd0, 8'd0, 1'b1, STATUS_OK}},
      '{MODE_OPEN,  16'h5555, 1,  1'b1, '{4'd0, 8'd1, 1'b0, STATUS_OK}},
      '{MODE_OPEN,  16'hAAAA, 1,  1'b1, '{4'd2, 8'd1, 1'b0, STATUS_OK}},
      '{MODE_OPEN,  16'h1230, 13, 1'b0, '{4'd0, 8'd0, 1'b0, STATUS_OK}},
      '{MODE_OPEN,  16'h0001, 1,  1'b1, '{4'd0, 8'd0, 1'b1, STATUS_FULL}},
      '{MODE_CLOSE, 16'hFFFF, 1,  1'b1, '{4'd1, 8'd0, 1'b1, STATUS_OK}},
      '{MODE_OPEN,  16'h0001, 1,  1'b1, '{4'd1, 8'd1, 1'b0, STATUS_OK}},
      '{MODE_CLOSE, 16'h0001, 1,  1'b1, '{4'd1, 8'd0, 1'b1, STATUS_OK}}
   };

   refcounted_open_sector_table i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_sector     (req_sector),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_slot       (rsp_slot),
      .rsp_open_count (rsp_open_count),
      .rsp_removable  (rsp_removable),
      .rsp_status     (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL refcounted_open_sector_table");
      $finish;
   end

   // updates the predicted table and returns the reply for one request
   function automatic sector_reply_t apply_sector_request(logic [MODE_BITS-1:0] mode,
                                                          logic [REQ_SECTOR_BITS-1:0] sector);
      sector_reply_t          reply;
      logic [SECTOR_BITS-1:0] key;
      int                     hit;
      int                     spare;
      key   = SECTOR_BITS'(sector);
      hit   = -1;
      spare = -1;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (slot_valid[i] && slot_sector[i] == key) hit = i;
         if (!slot_valid[i]) spare = i;
      end
      reply = '{slot: '0, open_count: '0, removable: 1'b1, status: STATUS_OK};
      case (mode)
         MODE_OPEN: begin
            if (hit >= 0) begin
               if (slot_count[hit] == COUNT_MAX) begin
                  reply.status = STATUS_OVERFLOW;
               end else begin
                  slot_count[hit] = slot_count[hit] + COUNT_BITS'(1);
               end
               reply.slot       = SLOT_BITS'(hit);
               reply.open_count = OPEN_COUNT_BITS'(slot_count[hit]);
               reply.removable  = 1'b0;
            end else if (spare < 0) begin
               reply.status = STATUS_FULL;
            end else begin
               slot_valid[spare]  = 1'b1;
               slot_sector[spare] = key;
               slot_count[spare]  = COUNT_BITS'(1);
               reply.slot         = SLOT_BITS'(spare);
               reply.open_count   = OPEN_COUNT_BITS'(1);
               reply.removable    = 1'b0;
            end
         end
         MODE_CLOSE: begin
            if (hit < 0) begin
               reply.status = STATUS_UNKNOWN;
            end else if (slot_count[hit] > COUNT_BITS'(1)) begin
               slot_count[hit]  = slot_count[hit] - COUNT_BITS'(1);
               reply.slot       = SLOT_BITS'(hit);
               reply.open_count = OPEN_COUNT_BITS'(slot_count[hit]);
               reply.removable  = 1'b0;
            end else begin
               slot_valid[hit] = 1'b0;
               slot_count[hit] = '0;
               reply.slot      = SLOT_BITS'(hit);
            end
         end
         default: begin
            if (hit >= 0) begin
               reply.slot       = SLOT_BITS'(hit);
               reply.open_count = OPEN_COUNT_BITS'(slot_count[hit]);
               reply.removable  = 1'b0;
            end
         end
      endcase
      return reply;
   endfunction

   function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $error("%s expected %0d actual %0d", name, want, got);
         fault_count++;
      end
   endfunction

   // entered just after a falling edge, returns just after a falling edge
   task automatic issue_request(logic [MODE_BITS-1:0] mode, logic [REQ_SECTOR_BITS-1:0] sector,
                                bit typed, sector_reply_t typed_reply, bit quiet);
      int            gap;
      sector_reply_t predicted;
      gap = quiet ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_mode   <= mode;
      req_sector <= sector;
      do @(posedge clock); while (req_stall);
      predicted = apply_sector_request(mode, sector);
      awaited_replies.push_back(typed ? typed_reply : predicted);
      @(negedge clock);
   endtask

   task automatic hold_until_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited_replies.size() != 0);
   endtask

   initial begin : rsp_pacing
      int hold;
      bit quiet;
      quiet     = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 31) == 0) quiet = !quiet;
         hold = quiet ? 0 : $urandom_range(0, 8);
         repeat (hold) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
         @(negedge clock);
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : rsp_check
      sector_reply_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_replies.size() == 0) begin
            $error("rsp transfer with no request outstanding");
            fault_count++;
         end else begin
            want = awaited_replies.pop_front();
            check_field("rsp_slot", 16'(want.slot), 16'(rsp_slot));
            check_field("rsp_open_count", 16'(want.open_count), 16'(rsp_open_count));
            check_field("rsp_removable", 16'(want.removable), 16'(rsp_removable));
            check_field("rsp_status", 16'(want.status), 16'(rsp_status));
         end
      end
   end

   initial begin : req_stimulus
      int                         issued;
      int                         pick;
      bit                         quiet;
      logic [MODE_BITS-1:0]       mode;
      logic [REQ_SECTOR_BITS-1:0] key;
      req_valid  = 1'b0;
      req_mode   = MODE_OPEN;
      req_sector = '0;
      reset      = 1'b1;
      quiet      = 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
         slot_valid[i]  = 1'b0;
         slot_sector[i] = '0;
         slot_count[i]  = '0;
      end
      key_pool[0]  = 16'h5555;
      key_pool[1]  = 16'hAAAA;
      key_pool[2]  = 16'hFFFF;
      key_pool[3]  = 16'h0001;
      for (int i = 0; i < 13; i++) key_pool[4 + i] = 16'h1230 + 16'(i);
      for (int i = 17; i < POOL_SIZE; i++) key_pool[i] = 16'($urandom);
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[r]) begin
         for (int n = 0; n < directed_rows[r].reps; n++) begin
            issue_request(directed_rows[r].mode, directed_rows[r].sector + 16'(n),
                          directed_rows[r].typed, directed_rows[r].reply, 1'b0);
         end
      end
      hold_until_drained();

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         if ($urandom_range(0, 31) == 0) quiet = !quiet;
         if (issued == HAMMER_AT) begin
            // drive one open sector into count saturation
            key = key_pool[0];
            for (int i = ENTRIES - 1; i >= 0; i--) begin
               if (slot_valid[i]) key = REQ_SECTOR_BITS'(slot_sector[i]);
            end
            for (int n = 0; n < HAMMER_OPENS; n++) begin
               issue_request(MODE_OPEN, key, 1'b0, '0, quiet || n[5]);
            end
            issued += HAMMER_OPENS;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 45)      mode = MODE_OPEN;
            else if (pick < 80) mode = MODE_CLOSE;
            else if (pick < 95) mode = MODE_QUERY;
            else                mode = MODE_SPARE;
            if ($urandom_range(0, 9) == 0) key = 16'($urandom);
            else key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
            issue_request(mode, key, 1'b0, '0, quiet);
            issued++;
            if ($urandom_range(0, 39) == 0) hold_until_drained();
         end
      end
      req_valid <= 1'b0;

      while (awaited_replies.size() != 0) @(posedge clock);
      repeat (4 * (ENTRIES + 3)) @(posedge clock);
      if (fault_count == 0 && awaited_replies.size() == 0) begin
         $display("PASS refcounted_open_sector_table");
      end else begin
         $display("FAIL refcounted_open_sector_table");
      end
      $finish;
   end

endmodule

### sim.f
rtl/rost_pkg.sv
rtl/rost_ram.sv
rtl/refcounted_open_sector_table.sv
verif/tb_refcounted_open_sector_table.sv
